// ----- hw/rtl/tsdf_pkg.sv -----
// shared types and constants for the tsdf weighted fusion unit
package tsdf_pkg;

	localparam int GRID_POINTS_DEF = 65536;
	localparam int NUM_W = 33;
	localparam int REM_W = 19;
	localparam int CNT_W = 6;
	localparam logic [16:0] Q_MAX = 17'd32768;
	localparam logic [0:0] REG_WEIGHT_CAP = 1'b0;

	typedef struct packed {
		logic [15:0]        grid_index;
		logic signed [15:0] sample_sdf;
		logic [15:0]        sample_weight;
		logic               sample_valid;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        out_index;
		logic signed [15:0] fused_dist;
		logic [15:0]        fused_weight;
		logic               updated;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SUM,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

endpackage

// ----- hw/rtl/tsdf_weighted_fusion_unit.sv -----
// tsdf weighted running-average fusion over a grid table held in one memory
//
// usage: an input item (grid index, distance sample, weight sample, valid flag)
// is taken at a clock edge with start high and busy low. The unit reads the
// grid entry, forms the weighted average and writes the entry back.
// Each item gives one result on the result port, marked by done for exactly
// one cycle; the receiver takes every result and cannot stall the unit.
// An item passes the states read, sum, fin and out; a fused one (valid, with
// nonzero weight and an index on the grid) also passes the divide state
// between sum and fin, where the restoring divider retires one quotient bit
// per cycle over a 33 bit dividend. busy stays high until the done cycle has
// passed, so one item is in flight at a time and a new one may start the cycle
// after done.
// The weight cap is written over the apb port; zero disables the weight cap.
// After reset the unit sweeps the memory to zero, one entry per cycle, over
// every grid entry while busy is high; configuration writes are taken then.
module tsdf_weighted_fusion_unit #(
	parameter int GRID_POINTS = tsdf_pkg::GRID_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tsdf_pkg::in_item_t in_item,
	output logic               done,
	output tsdf_pkg::result_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_POINTS - 1);

	tsdf_pkg::state_t state_q, state_nxt;

	logic [31:0] mem [GRID_POINTS];
	logic [31:0] rdata_q;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0] mem_wdata;
	logic        mem_re;
	logic [31:0] idx_ext;
	logic [31:0] wr_idx_ext;

	logic [15:0] weight_cap_q;
	logic [AW-1:0] clr_q;

	tsdf_pkg::in_item_t in_q;
	logic        range_q;
	logic signed [32:0] p1_s1, p2_s1;
	logic [16:0] den_q;
	logic [15:0] wnew_q;
	logic        neg_q;
	logic [tsdf_pkg::NUM_W-1:0] n_q;
	logic [tsdf_pkg::REM_W-1:0] rem_q;
	logic [tsdf_pkg::CNT_W-1:0] cnt_q;
	tsdf_pkg::result_t res_q;

	logic        fuse;
	logic signed [15:0] d_old;
	logic [15:0] w_old;
	logic [16:0] wsum;
	logic [15:0] wsat;
	logic signed [33:0] num;
	logic [32:0] mag;
	logic [tsdf_pkg::REM_W-1:0] rem_sh;
	logic [tsdf_pkg::REM_W-1:0] dvs;
	logic        qbit;
	logic [16:0] qclamp;
	logic signed [15:0] d_res;
	logic        cfg_wr;

	assign d_old = rdata_q[31:16];
	assign w_old = rdata_q[15:0];
	assign idx_ext = {16'd0, in_item.grid_index};
	assign wr_idx_ext = {16'd0, in_q.grid_index};
	assign fuse = range_q && in_q.sample_valid && (in_q.sample_weight != 16'd0);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == tsdf_pkg::REG_WEIGHT_CAP);
	assign prdata = (paddr[2] == tsdf_pkg::REG_WEIGHT_CAP) ? {16'd0, weight_cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_cap_q <= 16'd0;
		end else if (cfg_wr) begin
			weight_cap_q <= pwdata[15:0];
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tsdf_pkg::S_CLEAR: if (clr_q == LAST_ADDR) state_nxt = tsdf_pkg::S_IDLE;
			tsdf_pkg::S_IDLE:  if (start) state_nxt = tsdf_pkg::S_READ;
			tsdf_pkg::S_READ:  state_nxt = tsdf_pkg::S_SUM;
			tsdf_pkg::S_SUM:   state_nxt = fuse ? tsdf_pkg::S_DIV : tsdf_pkg::S_FIN;
			tsdf_pkg::S_DIV: begin
				if (cnt_q == tsdf_pkg::CNT_W'(tsdf_pkg::NUM_W - 1)) state_nxt = tsdf_pkg::S_FIN;
			end
			tsdf_pkg::S_FIN:   state_nxt = tsdf_pkg::S_OUT;
			tsdf_pkg::S_OUT:   state_nxt = tsdf_pkg::S_IDLE;
			default:           state_nxt = tsdf_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != tsdf_pkg::S_IDLE);
		done = (state_q == tsdf_pkg::S_OUT);
		result = res_q;
		mem_re = (state_q == tsdf_pkg::S_IDLE) && start;
		mem_we = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 32'd0;
		case (state_q)
			tsdf_pkg::S_CLEAR: mem_we = 1'b1;
			tsdf_pkg::S_FIN: begin
				mem_we = fuse;
				mem_waddr = wr_idx_ext[AW-1:0];
				mem_wdata = {d_res, wnew_q};
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsdf_pkg::S_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == tsdf_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// grid memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[idx_ext[AW-1:0]];
	end

	// weight sum, saturate then cap; numerator sum and its magnitude
	always_comb begin
		wsum = {1'b0, w_old} + {1'b0, in_q.sample_weight};
		wsat = wsum[16] ? 16'hffff : wsum[15:0];
		if (weight_cap_q != 16'd0 && wsat > weight_cap_q) wsat = weight_cap_q;
		num = 34'(p1_s1) + 34'(p2_s1);
		mag = num[33] ? 33'(-num) : num[32:0];
	end

	// restoring divide step
	always_comb begin
		dvs = {1'b0, den_q, 1'b0};
		rem_sh = {rem_q[tsdf_pkg::REM_W-2:0], n_q[tsdf_pkg::NUM_W-1]};
		qbit = (rem_sh >= dvs);
	end

	// round to nearest, ties away from zero, then clamp to q1.15
	always_comb begin
		qclamp = (n_q > 33'(tsdf_pkg::Q_MAX)) ? tsdf_pkg::Q_MAX : n_q[16:0];
		if (neg_q) d_res = 16'(-qclamp);
		else if (qclamp == tsdf_pkg::Q_MAX) d_res = 16'sh7fff;
		else d_res = qclamp[15:0];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tsdf_pkg::S_IDLE: begin
				in_q <= in_item;
				range_q <= (idx_ext < 32'(GRID_POINTS));
			end
			tsdf_pkg::S_READ: begin
				p1_s1 <= d_old * $signed({1'b0, w_old});
				p2_s1 <= in_q.sample_sdf * $signed({1'b0, in_q.sample_weight});
				den_q <= wsum;
				wnew_q <= wsat;
			end
			tsdf_pkg::S_SUM: begin
				neg_q <= num[33];
				n_q <= {mag[31:0], 1'b0} + 33'(den_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			tsdf_pkg::S_DIV: begin
				rem_q <= qbit ? rem_sh - dvs : rem_sh;
				n_q <= {n_q[tsdf_pkg::NUM_W-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
			end
			tsdf_pkg::S_FIN: begin
				res_q.out_index <= in_q.grid_index;
				res_q.updated <= fuse;
				if (fuse) begin
					res_q.fused_dist <= d_res;
					res_q.fused_weight <= wnew_q;
				end else if (range_q) begin
					res_q.fused_dist <= d_old;
					res_q.fused_weight <= w_old;
				end else begin
					res_q.fused_dist <= '0;
					res_q.fused_weight <= '0;
				end
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a busy interval");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.updated && weight_cap_q != 16'd0) |->
		result.fused_weight <= weight_cap_q)
		else $error("fused weight above cap");
	a_upd_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.updated) |-> result.fused_weight != 16'd0 || weight_cap_q == 16'd0)
		else $error("fused entry with zero weight");
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule
